// ----- rtl/imhq_pkg.sv -----
// imhq_pkg: shared types and constants of the indexed min-heap queue
// depends on: nothing
package imhq_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_ID_BITS  = 12;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 12;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 11;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_POP    = 2'd1,
        FN_CHANGE = 2'd2,
        FN_DELETE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOOKUP, S_POP_TAKE, S_POP_MOVE, S_DEL_MOVE,
        S_SET_CHK, S_SET_CMP, S_UP_CHK, S_UP_CMP, S_DN_CHK, S_DN_L,
        S_DN_R, S_DN_CMP, S_FINAL, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_FAIL, CMD_INS, CMD_POP_RD1,
        CMD_POP_TAKE, CMD_POP_MOVE, CMD_CHG, CMD_DEL, CMD_DEL_MOVE,
        CMD_RD_PARENT, CMD_UP_MOVE, CMD_RD_LEFT, CMD_TAKE_LEFT,
        CMD_TAKE_RIGHT, CMD_DN_MOVE, CMD_FINAL, CMD_EMIT
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        cmd_t    cmd;
        status_t st;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  in_valid;
        logic  clr_last;
        logic  pos_zero;
        logic  pos_last;
        logic  full;
        logic  cnt_zero;
        logic  cnt_gt1;
        logic  k_gt1;
        logic  kid_in;
        logic  c_lt_cnt;
        logic  par_gt;
        logic  par_ge;
        logic  dn_stop;
        logic  out_busy;
    } sts_t;

endpackage

// ----- rtl/imhq_if.sv -----
// imhq_req_if, imhq_rsp_if: valid/ready channels of the heap queue
// depends on: imhq_pkg
interface imhq_req_if;
    logic                     valid;
    logic                     ready;
    logic [imhq_pkg::FUNC_W-1:0] func;
    logic [imhq_pkg::ID_W-1:0]   item_id;
    logic signed [imhq_pkg::KEY_W-1:0] key;

    modport source (output valid, func, item_id, key, input ready);
    modport sink   (input valid, func, item_id, key, output ready);
endinterface

interface imhq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [imhq_pkg::STATUS_W-1:0] status;
    logic [imhq_pkg::ID_W-1:0]     out_id;
    logic signed [imhq_pkg::KEY_W-1:0] out_key;
    logic [imhq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_id, out_key, occupancy, input ready);
    modport sink   (input valid, status, out_id, out_key, occupancy, output ready);
endinterface

// ----- rtl/imhq_ctrl.sv -----
// imhq_ctrl: sequencer of the heap queue, one operation at a time
// depends on: imhq_pkg
module imhq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  imhq_pkg::sts_t sts,
    output imhq_pkg::ctl_t ctl,
    output logic           in_ready
);
    import imhq_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl.cmd    = CMD_NONE;
        ctl.st     = ST_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.cmd = CMD_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    ctl.cmd    = CMD_ACCEPT;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                unique case (sts.func)
                    FN_INSERT:
                    begin
                        if (!sts.pos_zero)
                        begin
                            ctl.cmd = CMD_FAIL;
                            ctl.st  = ST_PRESENT;
                            state_next = S_DONE;
                        end
                        else if (sts.full)
                        begin
                            ctl.cmd = CMD_FAIL;
                            ctl.st  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cmd = CMD_INS;
                            state_next = S_UP_CHK;
                        end
                    end
                    FN_POP:
                    begin
                        if (sts.cnt_zero)
                        begin
                            ctl.cmd = CMD_FAIL;
                            ctl.st  = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cmd = CMD_POP_RD1;
                            state_next = S_POP_TAKE;
                        end
                    end
                    FN_CHANGE:
                    begin
                        if (sts.pos_zero)
                        begin
                            ctl.cmd = CMD_FAIL;
                            ctl.st  = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cmd = CMD_CHG;
                            state_next = S_SET_CHK;
                        end
                    end
                    FN_DELETE:
                    begin
                        if (sts.pos_zero)
                        begin
                            ctl.cmd = CMD_FAIL;
                            ctl.st  = ST_ABSENT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cmd = CMD_DEL;
                            state_next = sts.pos_last ? S_DONE : S_DEL_MOVE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_POP_TAKE:
            begin
                ctl.cmd    = CMD_POP_TAKE;
                state_next = sts.cnt_gt1 ? S_POP_MOVE : S_DONE;
            end
            S_POP_MOVE:
            begin
                ctl.cmd    = CMD_POP_MOVE;
                state_next = S_DN_CHK;
            end
            S_DEL_MOVE:
            begin
                ctl.cmd    = CMD_DEL_MOVE;
                state_next = S_SET_CHK;
            end
            S_SET_CHK:
            begin
                if (sts.k_gt1)
                begin
                    ctl.cmd    = CMD_RD_PARENT;
                    state_next = S_SET_CMP;
                end
                else
                begin
                    state_next = S_DN_CHK;
                end
            end
            S_SET_CMP:
            begin
                if (sts.par_gt)
                begin
                    ctl.cmd    = CMD_UP_MOVE;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DN_CHK;
                end
            end
            S_UP_CHK:
            begin
                if (sts.k_gt1)
                begin
                    ctl.cmd    = CMD_RD_PARENT;
                    state_next = S_UP_CMP;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_UP_CMP:
            begin
                if (sts.par_ge)
                begin
                    ctl.cmd    = CMD_UP_MOVE;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_DN_CHK:
            begin
                if (sts.kid_in)
                begin
                    ctl.cmd    = CMD_RD_LEFT;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_DN_L:
            begin
                ctl.cmd    = CMD_TAKE_LEFT;
                state_next = sts.c_lt_cnt ? S_DN_R : S_DN_CMP;
            end
            S_DN_R:
            begin
                ctl.cmd    = CMD_TAKE_RIGHT;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    ctl.cmd    = CMD_DN_MOVE;
                    state_next = S_DN_CHK;
                end
            end
            S_FINAL:
            begin
                ctl.cmd    = CMD_FINAL;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.cmd    = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/imhq_dpath.sv -----
// imhq_dpath: heap slot memories, position map, sift registers, result word
// depends on: imhq_pkg
module imhq_dpath #(
    parameter int CAPACITY = imhq_pkg::DEF_CAPACITY,
    parameter int ID_BITS  = imhq_pkg::DEF_ID_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  imhq_pkg::ctl_t                     ctl,
    output imhq_pkg::sts_t                     sts,
    input  logic                               in_valid,
    input  logic [imhq_pkg::FUNC_W-1:0]        in_func,
    input  logic [imhq_pkg::ID_W-1:0]          in_item_id,
    input  logic signed [imhq_pkg::KEY_W-1:0]  in_key,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [imhq_pkg::STATUS_W-1:0]      out_status,
    output logic [imhq_pkg::ID_W-1:0]          out_id,
    output logic signed [imhq_pkg::KEY_W-1:0]  out_key,
    output logic [imhq_pkg::OCC_W-1:0]         out_occupancy
);
    import imhq_pkg::*;

    localparam int AW       = $clog2(CAPACITY + 1);
    localparam int ID_COUNT = 1 << ID_BITS;

    // heap slots 1..CAPACITY and the id to slot map
    logic [ID_BITS-1:0]      id_mem  [0:CAPACITY];
    logic signed [KEY_W-1:0] key_mem [0:CAPACITY];
    logic [AW-1:0]           map_mem [0:ID_COUNT-1];

    logic [ID_BITS-1:0]      rd_id_reg;
    logic signed [KEY_W-1:0] rd_key_reg;
    logic [AW-1:0]           map_rd_reg;

    func_t                   func_reg;
    logic [ID_BITS-1:0]      id_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [AW-1:0]           cnt_reg;
    logic [AW-1:0]           k_reg;
    logic [AW:0]             c_reg;
    logic [ID_BITS-1:0]      mid_reg;
    logic signed [KEY_W-1:0] mkey_reg;
    logic [ID_BITS-1:0]      cid_reg;
    logic signed [KEY_W-1:0] ckey_reg;
    status_t                 st_reg;
    logic [ID_BITS-1:0]      pid_reg;
    logic signed [KEY_W-1:0] pkey_reg;
    logic [ID_BITS-1:0]      clr_reg;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [ID_W-1:0]         out_id_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [OCC_W-1:0]        out_occ_reg;

    logic [AW-1:0]           pos;
    logic [AW:0]             left_idx;
    logic [AW-1:0]           heap_raddr;
    logic                    heap_we;
    logic [AW-1:0]           heap_waddr;
    logic [ID_BITS-1:0]      heap_wid;
    logic signed [KEY_W-1:0] heap_wkey;
    logic                    map_we;
    logic [ID_BITS-1:0]      map_waddr;
    logic [AW-1:0]           map_wdata;

    // stale map entries beyond the fill count read as absent
    assign pos      = (map_rd_reg > cnt_reg) ? '0 : map_rd_reg;
    assign left_idx = {k_reg, 1'b0};

    // status to the controller
    always_comb
    begin
        sts.func     = func_reg;
        sts.in_valid = in_valid;
        sts.clr_last = &clr_reg;
        sts.pos_zero = (pos == '0);
        sts.pos_last = (pos == cnt_reg);
        sts.full     = (cnt_reg >= AW'(CAPACITY));
        sts.cnt_zero = (cnt_reg == '0);
        sts.cnt_gt1  = (cnt_reg > AW'(1));
        sts.k_gt1    = (k_reg > AW'(1));
        sts.kid_in   = (left_idx <= {1'b0, cnt_reg});
        sts.c_lt_cnt = (c_reg < {1'b0, cnt_reg});
        sts.par_gt   = (rd_key_reg > mkey_reg);
        sts.par_ge   = (rd_key_reg >= mkey_reg);
        sts.dn_stop  = (mkey_reg <= ckey_reg);
        sts.out_busy = out_valid_reg && !out_ready;
    end

    // memory port selection
    always_comb
    begin
        heap_raddr = cnt_reg;
        heap_we    = 1'b0;
        heap_waddr = k_reg;
        heap_wid   = mid_reg;
        heap_wkey  = mkey_reg;
        map_we     = 1'b0;
        map_waddr  = mid_reg;
        map_wdata  = k_reg;
        case (ctl.cmd)
            CMD_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
            end
            CMD_POP_RD1:   heap_raddr = AW'(1);
            CMD_POP_TAKE:
            begin
                map_we    = 1'b1;
                map_waddr = rd_id_reg;
                map_wdata = '0;
            end
            CMD_DEL:
            begin
                map_we    = 1'b1;
                map_waddr = id_reg;
                map_wdata = '0;
            end
            CMD_RD_PARENT: heap_raddr = k_reg >> 1;
            CMD_RD_LEFT:   heap_raddr = left_idx[AW-1:0];
            CMD_TAKE_LEFT: heap_raddr = c_reg[AW-1:0] + AW'(1);
            CMD_UP_MOVE:
            begin
                heap_we   = 1'b1;
                heap_wid  = rd_id_reg;
                heap_wkey = rd_key_reg;
                map_we    = 1'b1;
                map_waddr = rd_id_reg;
            end
            CMD_DN_MOVE:
            begin
                heap_we   = 1'b1;
                heap_wid  = cid_reg;
                heap_wkey = ckey_reg;
                map_we    = 1'b1;
                map_waddr = cid_reg;
            end
            CMD_FINAL:
            begin
                heap_we = 1'b1;
                map_we  = 1'b1;
            end
            default: ;
        endcase
    end

    // heap slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            id_mem[heap_waddr]  <= heap_wid;
            key_mem[heap_waddr] <= heap_wkey;
        end
        rd_id_reg  <= id_mem[heap_raddr];
        rd_key_reg <= key_mem[heap_raddr];
    end

    // position map memory, read at the incoming id
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rd_reg <= map_mem[ID_BITS'(in_item_id)];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cmd == CMD_CLEAR)
            begin
                clr_reg <= clr_reg + ID_BITS'(1);
            end
            case (ctl.cmd)
                CMD_INS:      cnt_reg <= cnt_reg + AW'(1);
                CMD_DEL:      cnt_reg <= cnt_reg - AW'(1);
                CMD_POP_MOVE: cnt_reg <= cnt_reg - AW'(1);
                CMD_POP_TAKE:
                begin
                    if (!sts.cnt_gt1)
                    begin
                        cnt_reg <= '0;
                    end
                end
                default: ;
            endcase
            if (ctl.cmd == CMD_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sift and result registers
    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CMD_ACCEPT:
            begin
                func_reg <= func_t'(in_func);
                id_reg   <= ID_BITS'(in_item_id);
                key_reg  <= in_key;
                st_reg   <= ST_OK;
                pid_reg  <= '0;
                pkey_reg <= '0;
            end
            CMD_FAIL: st_reg <= ctl.st;
            CMD_INS:
            begin
                k_reg    <= cnt_reg + AW'(1);
                mid_reg  <= id_reg;
                mkey_reg <= key_reg;
            end
            CMD_POP_TAKE:
            begin
                pid_reg  <= rd_id_reg;
                pkey_reg <= rd_key_reg;
            end
            CMD_POP_MOVE:
            begin
                mid_reg  <= rd_id_reg;
                mkey_reg <= rd_key_reg;
                k_reg    <= AW'(1);
            end
            CMD_CHG:
            begin
                mid_reg  <= id_reg;
                mkey_reg <= key_reg;
                k_reg    <= pos;
            end
            CMD_DEL:      k_reg <= pos;
            CMD_DEL_MOVE:
            begin
                mid_reg  <= rd_id_reg;
                mkey_reg <= rd_key_reg;
            end
            CMD_UP_MOVE:  k_reg <= k_reg >> 1;
            CMD_RD_LEFT:  c_reg <= left_idx;
            CMD_TAKE_LEFT:
            begin
                cid_reg  <= rd_id_reg;
                ckey_reg <= rd_key_reg;
            end
            CMD_TAKE_RIGHT:
            begin
                // right child wins only when left is strictly greater
                if (ckey_reg > rd_key_reg)
                begin
                    cid_reg  <= rd_id_reg;
                    ckey_reg <= rd_key_reg;
                    c_reg    <= c_reg + (AW+1)'(1);
                end
            end
            CMD_DN_MOVE:  k_reg <= c_reg[AW-1:0];
            CMD_EMIT:
            begin
                out_status_reg <= st_reg;
                out_id_reg     <= ID_W'(pid_reg);
                out_key_reg    <= pkey_reg;
                out_occ_reg    <= OCC_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_id        = out_id_reg;
    assign out_key       = out_key_reg;
    assign out_occupancy = out_occ_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= AW'(CAPACITY))
        else $error("entry count above capacity");
    a_fail_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == CMD_FAIL) |=> $stable(cnt_reg))
        else $error("rejected operation changed entry count");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == CMD_EMIT) |=> out_valid_reg)
        else $error("result word not presented");
    a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == CMD_DN_MOVE) |-> (c_reg <= {1'b0, cnt_reg}))
        else $error("sift-down child beyond fill count");

endmodule

// ----- rtl/indexed_min_heap_queue_unit.sv -----
// indexed_min_heap_queue_unit: top level, indexed binary min-heap queue
// depends on: imhq_pkg, imhq_if, imhq_ctrl, imhq_dpath
// one operation at a time: lookup, then sift-up with a parent read and compare per
// level or sift-down with left and right child reads and a compare per level, plus
// write-back and result word
// after reset the position map is swept to absent, all 2**ID_BITS entries
// (4096 by default), before the first word is accepted
module indexed_min_heap_queue_unit #(
    parameter int CAPACITY = imhq_pkg::DEF_CAPACITY,
    parameter int ID_BITS  = imhq_pkg::DEF_ID_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    imhq_req_if.sink   req,
    imhq_rsp_if.source rsp
);
    import imhq_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    // sequencer
    imhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .ctl      (ctl),
        .in_ready (in_ready)
    );

    // heap storage and sift datapath
    imhq_dpath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .in_valid      (req.valid),
        .in_func       (req.func),
        .in_item_id    (req.item_id),
        .in_key        (req.key),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .out_status    (rsp.status),
        .out_id        (rsp.out_id),
        .out_key       (rsp.out_key),
        .out_occupancy (rsp.occupancy)
    );

endmodule

// ----- verif/tb_indexed_min_heap_queue_unit.sv -----
// testbench for indexed_min_heap_queue_unit: random and directed heap operations
// checked word by word against a behavioral heap model held in a scoreboard class
// depends on: imhq_pkg, imhq_if, indexed_min_heap_queue_unit
`timescale 1ns / 100ps

module tb_indexed_min_heap_queue_unit;
    import imhq_pkg::*;

    localparam int CAP = 1024;
    localparam int NUM_IDS = 4096;
    localparam int RANDOM_WORDS = 100;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      out_id;
        logic signed [KEY_W-1:0] out_key;
        logic [OCC_W-1:0]     occupancy;
    } heap_result_t;

    // heap model and queue of expected result words
    class heap_scoreboard;
        logic [ID_W-1:0]         hid[CAP+1];
        logic signed [KEY_W-1:0] hkey[CAP+1];
        int unsigned             where[NUM_IDS];
        int unsigned             count;
        heap_result_t            pending[$];
        int                      errors;

        function void clear();
            foreach (where[i]) where[i] = 0;
            count = 0;
            errors = 0;
        endfunction

        function void place(int unsigned k, logic [ID_W-1:0] id, logic signed [KEY_W-1:0] kv);
            hid[k] = id;
            hkey[k] = kv;
            where[id] = k;
        endfunction

        function void rise(int unsigned k);
            logic [ID_W-1:0] id;
            logic signed [KEY_W-1:0] kv;
            id = hid[k];
            kv = hkey[k];
            while (k > 1 && hkey[k/2] >= kv) begin
                place(k, hid[k/2], hkey[k/2]);
                k = k / 2;
            end
            place(k, id, kv);
        endfunction

        function void sink(int unsigned k);
            logic [ID_W-1:0] id;
            logic signed [KEY_W-1:0] kv;
            int unsigned c;
            id = hid[k];
            kv = hkey[k];
            while (2*k <= count) begin
                c = 2*k;
                if (c < count && hkey[c] > hkey[c+1])
                    c++;
                if (kv <= hkey[c])
                    break;
                place(k, hid[c], hkey[c]);
                k = c;
            end
            place(k, id, kv);
        endfunction

        function void resettle(int unsigned k);
            if (k > 1 && hkey[k/2] > hkey[k])
                rise(k);
            else
                sink(k);
        endfunction

        // apply one accepted request and queue its result word
        function void note_request(func_t fn, logic [ID_W-1:0] id, logic signed [KEY_W-1:0] kv);
            heap_result_t r;
            int unsigned pos;
            r = '0;
            r.status = ST_OK;
            pos = where[id];
            if (pos > count)
                pos = 0;
            case (fn)
                FN_INSERT:
                    if (pos != 0)
                        r.status = ST_PRESENT;
                    else if (count >= CAP)
                        r.status = ST_FULL;
                    else
                    begin
                        count++;
                        place(count, id, kv);
                        rise(count);
                    end
                FN_POP:
                    if (count == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.out_id = hid[1];
                        r.out_key = hkey[1];
                        if (count > 1)
                        begin
                            place(1, hid[count], hkey[count]);
                            count--;
                            sink(1);
                        end
                        else
                            count = 0;
                        where[r.out_id] = 0;
                    end
                FN_CHANGE:
                    if (pos == 0)
                        r.status = ST_ABSENT;
                    else
                    begin
                        hkey[pos] = kv;
                        resettle(pos);
                    end
                default:
                    if (pos == 0)
                        r.status = ST_ABSENT;
                    else
                    begin
                        if (pos != count)
                            place(pos, hid[count], hkey[count]);
                        count--;
                        where[id] = 0;
                        if (pos <= count)
                            resettle(pos);
                    end
            endcase
            r.occupancy = count[OCC_W-1:0];
            pending.push_back(r);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(heap_result_t got);
            heap_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.out_id !== want.out_id ||
                got.out_key !== want.out_key || got.occupancy !== want.occupancy)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected st=%0d id=%0d key=%0d occ=%0d,",
                              " got st=%0d id=%0d key=%0d occ=%0d"},
                             want.status, want.out_id, want.out_key, want.occupancy,
                             got.status, got.out_id, got.out_key, got.occupancy);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    imhq_req_if req ();
    imhq_rsp_if rsp ();

    heap_scoreboard board;
    bit  no_idle;
    longint cycles;
    logic [ID_W-1:0] used_ids[$];

    indexed_min_heap_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // observe accepted words on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                board.note_request(func_t'(req.func), req.item_id, req.key);
            if (rsp.valid && rsp.ready)
                board.check_result({status_t'(rsp.status), rsp.out_id, rsp.out_key, rsp.occupancy});
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= no_idle || ($urandom_range(0, 99) >= 18);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // send one request word, with random idle before it
    task automatic send_word(func_t fn, logic [ID_W-1:0] id, logic signed [KEY_W-1:0] kv);
        while (!no_idle && $urandom_range(0, 99) < 18)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.func    <= fn;
        req.item_id <= id;
        req.key     <= kv;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // pick an id: mostly one seen before, sometimes fresh
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] id;
        if (used_ids.size() > 0 && $urandom_range(0, 99) < 75)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        id = $urandom_range(0, NUM_IDS - 1);
        if (used_ids.size() < 300)
            used_ids.push_back(id);
        return id;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(0, 15))) - 8;
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'h7fff_ffff - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [ID_W-1:0] id;
        int unsigned sel;
        board = new();
        board.clear();
        cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        req.valid <= 1'b0;
        req.func <= FN_INSERT;
        req.item_id <= '0;
        req.key <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, duplicates, last-slot delete, equal-key change
        send_word(FN_POP, 12'd0, 32'sd0);
        send_word(FN_CHANGE, 12'd5, 32'sd1);
        send_word(FN_DELETE, 12'hfff, 32'sd0);
        send_word(FN_INSERT, 12'hfff, 32'h7fff_ffff);
        send_word(FN_INSERT, 12'd0, 32'h8000_0000);
        send_word(FN_INSERT, 12'hfff, 32'sd3);
        send_word(FN_INSERT, 12'h555, 32'sd0);
        send_word(FN_INSERT, 12'haaa, 32'sd0);
        send_word(FN_CHANGE, 12'h555, 32'sd0);
        send_word(FN_CHANGE, 12'hfff, -32'sd5);
        send_word(FN_DELETE, 12'haaa, 32'sd0);
        send_word(FN_DELETE, 12'h0, 32'sd0);
        send_word(FN_POP, 12'd0, 32'sd0);
        send_word(FN_POP, 12'd0, 32'sd0);
        send_word(FN_POP, 12'd0, 32'sd0);
        drop_valid();
        wait_drained();

        // fill to capacity and one past it to reach the full case, then one more
        no_idle = 1'b1;
        for (int i = 0; i <= CAP; i++)
            send_word(FN_INSERT, 12'(i * 3), pick_key());
        send_word(FN_INSERT, 12'hffe, 32'sd1);
        // take some out again by pops and deletes
        for (int i = 0; i < 40; i++)
            send_word(FN_POP, 12'd0, 32'sd0);
        for (int i = 0; i < 30; i++)
            send_word(FN_DELETE, 12'($urandom_range(0, CAP) * 3), 32'sd0);
        no_idle = 1'b0;
        drop_valid();
        wait_drained();

        // random mix, short stretch without idling in the middle
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            no_idle = (n >= 30 && n < 60);
            id = pick_id();
            sel = $urandom_range(0, 99);
            if (sel < 35)
                send_word(FN_INSERT, id, pick_key());
            else if (sel < 60)
                send_word(FN_POP, 12'($urandom), $urandom);
            else if (sel < 82)
                send_word(FN_CHANGE, id, pick_key());
            else
                send_word(FN_DELETE, id, $urandom);
        end
        drop_valid();
        no_idle = 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
